### hdl/pdwa_pkg.sv
// Shared types and constants for the priority dispatcher with aging.
// No dependencies; imported by pdwa_cell, priority_dispatch_with_aging_top, dispatch_monitor and testbench.
package pdwa_pkg;

  localparam int unsigned BURST_W   = 8;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned QUANTUM_W = 8;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd5;
  localparam logic                 ACT_LOAD      = 1'b0;
  localparam logic                 ACT_DISPATCH  = 1'b1;

  // Best candidate seen so far, handed from cell to cell during a scan
  typedef struct packed {
    logic               valid;
    logic [BURST_W-1:0] burst;
    logic [LEVEL_W-1:0] level;
  } cand_t;

  // Slot contents written by a load
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [LEVEL_W-1:0] level;
  } load_t;

  // Write-back of the dispatched slot
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [LEVEL_W-1:0] level;
    logic               done;
  } upd_t;

endpackage

### hdl/pdwa_cell.sv
// One task slot of the dispatch chain: burst, level and active mark, plus one
// registered stage of the running maximum search. Depends on pdwa_pkg.
module pdwa_cell
  import pdwa_pkg::*;
#(
  parameter int unsigned IDX_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_en_i,
  input  load_t            ld_i,
  input  logic             upd_en_i,
  input  upd_t             upd_i,
  input  logic [IDX_W-1:0] own_idx_i,
  input  cand_t            cand_i,
  input  logic [IDX_W-1:0] cand_idx_i,
  output cand_t            cand_o,
  output logic [IDX_W-1:0] cand_idx_o
);

  logic               active_q, active_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  cand_t              cand_q, cand_d;
  logic [IDX_W-1:0]   cand_idx_q, cand_idx_d;
  logic               take;

  always_comb begin
    active_d = active_q;
    burst_d  = burst_q;
    level_d  = level_q;
    if (ld_en_i) begin
      burst_d  = ld_i.burst;
      level_d  = ld_i.level;
      active_d = (ld_i.burst != '0);
    end else if (upd_en_i) begin
      burst_d = upd_i.burst;
      level_d = upd_i.level;
      if (upd_i.done) begin
        active_d = 1'b0;
      end
    end
  end

  // Strictly greater keeps the earlier (lower) index on a tie
  assign take = active_q && (!cand_i.valid || (level_q > cand_i.level));

  always_comb begin
    cand_d     = cand_i;
    cand_idx_d = cand_idx_i;
    if (take) begin
      cand_d.valid = 1'b1;
      cand_d.burst = burst_q;
      cand_d.level = level_q;
      cand_idx_d   = own_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q    <= burst_d;
    level_q    <= level_d;
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;

endmodule

### hdl/priority_dispatch_with_aging_top.sv
// Priority dispatcher with aging: a chain of SLOTS cells searched in a pipeline.
// Load: accepted whenever not busy, no result; the next word may follow at once.
// Dispatch: the scan runs through the cell chain in ST_SCAN, the winner is written
// back in ST_UPD, and the result strobe is registered from ST_UPD.
// busy is high from acceptance until the result cycle; results cannot stall.
// Reset clears all active marks and sets quantum to 5; no clearing pass.
module priority_dispatch_with_aging_top
  import pdwa_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [LEVEL_W-1:0]   level_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [QUANTUM_W-1:0] cfg_data_i,
  output logic                 out_valid_o,
  output logic [SLOT_W-1:0]    chosen_o,
  output logic                 none_ready_o,
  output logic [BURST_W-1:0]   remaining_o,
  output logic [LEVEL_W-1:0]   new_level_o,
  output logic                 finished_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [QUANTUM_W-1:0] quantum_q;

  logic                 accept;
  logic                 ld_fire;
  load_t                ld_word;
  upd_t                 upd_word;
  logic [SLOTS-1:0]     ld_en;
  logic [SLOTS-1:0]     upd_en;

  cand_t                cand_w     [SLOTS+1];
  logic [IDX_W-1:0]     cand_idx_w [SLOTS+1];

  cand_t                best;
  logic [IDX_W-1:0]     best_idx;
  logic [BURST_W-1:0]   rem;
  logic [LEVEL_W-1:0]   lvl;
  logic                 done;

  logic                 out_valid_q;
  logic [SLOT_W-1:0]    chosen_q;
  logic                 none_ready_q;
  logic [BURST_W-1:0]   remaining_q;
  logic [LEVEL_W-1:0]   new_level_q;
  logic                 finished_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign ld_fire     = accept && (action_i == ACT_LOAD);
  assign cfg_ready_o = 1'b1;

  assign ld_word.burst = burst_i;
  assign ld_word.level = level_i;

  // Age the winner of the scan
  assign best     = cand_w[SLOTS];
  assign best_idx = cand_idx_w[SLOTS];
  assign rem      = (best.burst >= quantum_q) ? (best.burst - quantum_q) : '0;
  assign lvl      = (best.level > LEVEL_W'(1)) ? (best.level - LEVEL_W'(1)) : best.level;
  assign done     = (rem == '0);

  assign upd_word.burst = rem;
  assign upd_word.level = lvl;
  assign upd_word.done  = done;

  assign cand_w[0]     = '0;
  assign cand_idx_w[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign ld_en[i]  = ld_fire && (32'(slot_i) == i);
    assign upd_en[i] = (state_q == ST_UPD) && best.valid && (best_idx == IDX_W'(i));

    pdwa_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ld_en_i    (ld_en[i]),
      .ld_i       (ld_word),
      .upd_en_i   (upd_en[i]),
      .upd_i      (upd_word),
      .own_idx_i  (IDX_W'(i)),
      .cand_i     (cand_w[i]),
      .cand_idx_i (cand_idx_w[i]),
      .cand_o     (cand_w[i+1]),
      .cand_idx_o (cand_idx_w[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_DISPATCH)) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        // the last cell holds the answer once every stage has advanced
        if (cnt_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      quantum_q   <= QUANTUM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= (state_q == ST_UPD);
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      if (best.valid) begin
        chosen_q     <= SLOT_W'(best_idx);
        none_ready_q <= 1'b0;
        remaining_q  <= rem;
        new_level_q  <= lvl;
        finished_q   <= done;
      end else begin
        chosen_q     <= '0;
        none_ready_q <= 1'b1;
        remaining_q  <= '0;
        new_level_q  <= '0;
        finished_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chosen_o     = chosen_q;
  assign none_ready_o = none_ready_q;
  assign remaining_o  = remaining_q;
  assign new_level_o  = new_level_q;
  assign finished_o   = finished_q;

`ifndef SYNTH
  a_strobe_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_UPD))
    else $error("result strobe without a write-back cycle");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("busy during result cycle");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_ready_o) |-> (chosen_o == '0 && remaining_o == '0 && !finished_o))
    else $error("empty dispatch carries data");

  a_finished_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (remaining_o == '0))
    else $error("retired slot with burst left");
`endif

endmodule

### tb/sv/dispatch_monitor.sv
// Checker for the priority dispatcher with aging: tracks the slot table,
// predicts each dispatch result and compares it with the result strobe.
// Depends on pdwa_pkg for field widths, action codes and the quantum reset value.
module dispatch_monitor
  import pdwa_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 action_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [LEVEL_W-1:0]   level_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [QUANTUM_W-1:0] cfg_data_i,
  input  logic                 out_valid_o,
  input  logic [SLOT_W-1:0]    chosen_o,
  input  logic                 none_ready_o,
  input  logic [BURST_W-1:0]   remaining_o,
  input  logic [LEVEL_W-1:0]   new_level_o,
  input  logic                 finished_o,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [SLOT_W-1:0]  chosen;
    logic               none_ready;
    logic [BURST_W-1:0] remaining;
    logic [LEVEL_W-1:0] new_level;
    logic               finished;
  } dispatch_res_t;

  logic [BURST_W-1:0]   burst_mem [SLOTS];
  logic [LEVEL_W-1:0]   level_mem [SLOTS];
  logic [SLOTS-1:0]     live;
  logic [QUANTUM_W-1:0] quantum;
  dispatch_res_t        dispatch_due_q [$];
  int                   errors;

  // Pick the live slot with the highest level (lowest index on a tie), then
  // charge it one quantum and age it; with no live slot, report none ready.
  function automatic dispatch_res_t pick_and_age();
    dispatch_res_t      res;
    int                 best;
    logic [LEVEL_W-1:0] best_lvl;
    logic [BURST_W-1:0] rem;
    res      = '0;
    best     = -1;
    best_lvl = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && (best < 0 || level_mem[i] > best_lvl)) begin
        best     = i;
        best_lvl = level_mem[i];
      end
    end
    if (best < 0) begin
      res.none_ready = 1'b1;
      return res;
    end
    rem = (burst_mem[best] >= quantum) ? burst_mem[best] - quantum : '0;
    if (best_lvl > 1) best_lvl = best_lvl - 1'b1;
    burst_mem[best] = rem;
    level_mem[best] = best_lvl;
    if (rem == '0) live[best] = 1'b0;
    res.chosen    = SLOT_W'(best);
    res.remaining = rem;
    res.new_level = best_lvl;
    res.finished  = (rem == '0);
    return res;
  endfunction

  function automatic void flag_error(input string what, input dispatch_res_t want,
                                     input dispatch_res_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected chosen=%0d none=%0b rem=%0d lvl=%0d fin=%0b",
               $time, what, want.chosen, want.none_ready, want.remaining,
               want.new_level, want.finished);
      $display("%0t %s:   actual chosen=%0d none=%0b rem=%0d lvl=%0d fin=%0b",
               $time, what, got.chosen, got.none_ready, got.remaining,
               got.new_level, got.finished);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_res_t got;
    dispatch_res_t want;
    if (!rst_ni) begin
      quantum = QUANTUM_RESET;
      live    = '0;
      dispatch_due_q.delete();
      errors       = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_o) begin
        got = '{chosen: chosen_o, none_ready: none_ready_o, remaining: remaining_o,
                new_level: new_level_o, finished: finished_o};
        if (dispatch_due_q.size() == 0) begin
          flag_error("unexpected result", '0, got);
        end else begin
          want = dispatch_due_q.pop_front();
          if (got.chosen !== want.chosen || got.none_ready !== want.none_ready ||
              got.remaining !== want.remaining || got.new_level !== want.new_level ||
              got.finished !== want.finished) begin
            flag_error("result mismatch", want, got);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) quantum = cfg_data_i;
      if (start && !busy) begin
        if (action_i == ACT_LOAD) begin
          // drop loads to slots the table does not have
          if (slot_i < SLOTS) begin
            burst_mem[slot_i] = burst_i;
            level_mem[slot_i] = level_i;
            live[slot_i]      = (burst_i != '0);
          end
        end else begin
          dispatch_due_q.push_back(pick_and_age());
        end
      end
      pending_o    = dispatch_due_q.size();
      fail_count_o = errors;
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the dispatcher regression: clock, reset, command and quantum stimulus,
// and the verdict. Depends on pdwa_pkg, priority_dispatch_with_aging_top and
// dispatch_monitor, which does all prediction and comparison.
module testbench;
  import pdwa_pkg::*;

  localparam int unsigned NUM_SLOTS    = 8;
  localparam int unsigned DRAIN_CYCLES = NUM_SLOTS + 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned RANDOM_ITEMS = 1600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [SLOT_W-1:0]    slot_i;
  logic [BURST_W-1:0]   burst_i;
  logic [LEVEL_W-1:0]   level_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [QUANTUM_W-1:0] cfg_data_i;
  logic                 out_valid_o;
  logic [SLOT_W-1:0]    chosen_o;
  logic                 none_ready_o;
  logic [BURST_W-1:0]   remaining_o;
  logic [LEVEL_W-1:0]   new_level_o;
  logic                 finished_o;
  int                   fail_count;
  int                   pending;
  logic                 free_run;

  priority_dispatch_with_aging_top #(.SLOTS(NUM_SLOTS)) dut (.*);

  dispatch_monitor #(.SLOTS(NUM_SLOTS)) monitor (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one command word from a falling edge, hold it until accepted,
  // then idle for a random gap unless free running.
  task automatic send_word(input logic act, input logic [SLOT_W-1:0] s,
                           input logic [BURST_W-1:0] b, input logic [LEVEL_W-1:0] l);
    int roll;
    int gap;
    start    = 1'b1;
    action_i = act;
    slot_i   = s;
    burst_i  = b;
    level_i  = l;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    roll = $urandom_range(0, 99);
    if (free_run || roll < 55) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start    = 1'b0;
      action_i = 1'($urandom);
      slot_i   = SLOT_W'($urandom);
      burst_i  = BURST_W'($urandom);
      level_i  = LEVEL_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Write the quantum only once every dispatch has reported and the last
  // load has had time to settle.
  task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = q;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = QUANTUM_W'($urandom);
  endtask

  initial begin
    logic [QUANTUM_W-1:0] q;
    logic [BURST_W-1:0]   b;
    logic [LEVEL_W-1:0]   l;
    int                   load_pct;
    int                   roll;
    start       = 1'b0;
    action_i    = ACT_LOAD;
    slot_i      = '0;
    burst_i     = '0;
    level_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    free_run    = 1'b0;
    rst_ni      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table first, then a tie at the top level and the odd loads
    send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom), LEVEL_W'($urandom));
    send_word(ACT_LOAD, 3'd0, 8'd255, 4'd15);
    send_word(ACT_LOAD, 3'd3, 8'd12, 4'd15);
    send_word(ACT_LOAD, 3'd7, 8'd1, 4'd1);
    send_word(ACT_LOAD, 3'd5, 8'd0, 4'd9);
    send_word(ACT_LOAD, 3'd6, 8'd3, 4'd0);
    repeat (4) send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom),
                         LEVEL_W'($urandom));
    set_quantum(8'd255);
    repeat (6) send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom),
                         LEVEL_W'($urandom));
    // a zero quantum never finishes a task, only ages it
    set_quantum(8'd0);
    send_word(ACT_LOAD, 3'd2, 8'd1, 4'd2);
    repeat (3) send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom),
                         LEVEL_W'($urandom));
    set_quantum(8'd1);
    send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom), LEVEL_W'($urandom));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: q = 8'd1;
        1: q = 8'd255;
        default: q = QUANTUM_W'($urandom_range(0, 1) ? $urandom_range(2, 20)
                                                     : $urandom_range(21, 254));
      endcase
      set_quantum(q);
      load_pct = $urandom_range(25, 55);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) free_run = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < load_pct) begin
          roll = $urandom_range(0, 15);
          if (roll == 0) b = '0;
          else if (roll < 5) b = BURST_W'($urandom_range(1, 8));
          else b = BURST_W'($urandom_range(1, 255));
          l = ($urandom_range(0, 15) == 0) ? '0 : LEVEL_W'($urandom_range(1, 15));
          send_word(ACT_LOAD, SLOT_W'($urandom), b, l);
        end else begin
          send_word(ACT_DISPATCH, SLOT_W'($urandom), BURST_W'($urandom),
                    LEVEL_W'($urandom));
        end
      end
    end
    free_run = 1'b0;

    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
